### hw/rtl/gmsb_pkg.sv
// shared types and constants for the gate motor stall backoff sequencer
`default_nettype none
package gmsb_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_DOWN    = 2'd1,
        MODE_BACKOFF = 2'd2,
        MODE_UP      = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        OP_TICK           = 3'd0,
        OP_DOWN           = 3'd1,
        OP_UP             = 3'd2,
        OP_STOP_GATE      = 3'd3,
        OP_COLLECT        = 3'd4,
        OP_EJECT          = 3'd5,
        OP_STOP_COLLECTOR = 3'd6,
        OP_STOP_ALL       = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        CFG_STALL_LIMIT_DOWN  = 2'd0,
        CFG_STALL_COUNT_LIMIT = 2'd1,
        CFG_BACKOFF_TICKS     = 2'd2,
        CFG_RETURN_TICKS      = 2'd3
    } cfg_idx_t;

    localparam int CFG_DATA_BITS = 16;
    localparam int LIMIT_BITS    = 12;
    localparam int OP_BITS       = 3;
    localparam int DRIVE_BITS    = 8;

    localparam logic [LIMIT_BITS-1:0]    RST_STALL_LIMIT_DOWN  = 12'd320;
    localparam logic [CFG_DATA_BITS-1:0] RST_STALL_COUNT_LIMIT = 16'd5;
    localparam logic [CFG_DATA_BITS-1:0] RST_BACKOFF_TICKS     = 16'd10;
    localparam logic [CFG_DATA_BITS-1:0] RST_RETURN_TICKS      = 16'd50;

    localparam logic signed [DRIVE_BITS-1:0] DRIVE_OFF     = 8'sd0;
    localparam logic signed [DRIVE_BITS-1:0] DRIVE_DOWN    = 8'sd30;
    localparam logic signed [DRIVE_BITS-1:0] DRIVE_UP      = -8'sd60;
    localparam logic signed [DRIVE_BITS-1:0] DRIVE_BACKOFF = -8'sd30;
    localparam logic signed [DRIVE_BITS-1:0] DRIVE_COLLECT = 8'sd100;
    localparam logic signed [DRIVE_BITS-1:0] DRIVE_EJECT   = -8'sd100;

    typedef struct packed {
        logic [LIMIT_BITS-1:0]    stall_limit_down;
        logic [CFG_DATA_BITS-1:0] stall_count_limit;
        logic [CFG_DATA_BITS-1:0] backoff_ticks;
        logic [CFG_DATA_BITS-1:0] return_ticks;
    } cfg_t;

    typedef struct packed {
        logic signed [DRIVE_BITS-1:0] motor_drive;
        logic signed [DRIVE_BITS-1:0] collector_drive;
        logic                         gate_moving;
    } drive_t;

endpackage
`default_nettype wire

### hw/rtl/gmsb_item_if.sv
// input channel: command or tick with current sample
`default_nettype none
interface gmsb_item_if #(
    parameter int CURRENT_BITS = 12
);
    logic                           valid;
    logic                           ready;
    logic [gmsb_pkg::OP_BITS-1:0]   operation;
    logic [CURRENT_BITS-1:0]        current_sample;

    modport source (output valid, output operation, output current_sample, input ready);
    modport sink (input valid, input operation, input current_sample, output ready);
endinterface
`default_nettype wire

### hw/rtl/gmsb_result_if.sv
// output channel: motor and collector drives and moving flag
`default_nettype none
interface gmsb_result_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [gmsb_pkg::DRIVE_BITS-1:0] motor_drive;
    logic signed [gmsb_pkg::DRIVE_BITS-1:0] collector_drive;
    logic                                   gate_moving;

    modport source (output valid, output motor_drive, output collector_drive,
                    output gate_moving, input ready);
    modport sink (input valid, input motor_drive, input collector_drive,
                  input gate_moving, output ready);
endinterface
`default_nettype wire

### hw/rtl/gmsb_core.sv
// sequencer state and single-pass update for one beat
`default_nettype none
module gmsb_core #(
    parameter int COUNT_BITS   = 16,
    parameter int CURRENT_BITS = 12
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         fire,
    input  wire logic [gmsb_pkg::OP_BITS-1:0] operation,
    input  wire logic [CURRENT_BITS-1:0]      current_sample,
    input  wire gmsb_pkg::cfg_t               cfg,
    output gmsb_pkg::drive_t                  drive_next
);
    localparam int CMP_BITS = (COUNT_BITS > gmsb_pkg::CFG_DATA_BITS) ?
                              COUNT_BITS : gmsb_pkg::CFG_DATA_BITS;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    gmsb_pkg::mode_t mode_reg, mode_next;
    logic signed [gmsb_pkg::DRIVE_BITS-1:0] motor_reg, motor_next;
    logic signed [gmsb_pkg::DRIVE_BITS-1:0] coll_reg, coll_next;
    logic [COUNT_BITS-1:0] stall_reg, stall_next;
    logic [COUNT_BITS-1:0] back_reg, back_next;
    logic [COUNT_BITS-1:0] ret_reg, ret_next;

    gmsb_pkg::op_t op;
    logic [CURRENT_BITS-1:0] limit_cur;
    logic [COUNT_BITS-1:0] back_inc, stall_inc, ret_inc;
    logic over_limit, stall_hit, backoff_run, up_done;

    assign op        = gmsb_pkg::op_t'(operation);
    assign limit_cur = CURRENT_BITS'(cfg.stall_limit_down);
    assign back_inc  = (back_reg == CNT_MAX) ? CNT_MAX : back_reg + 1'b1;
    assign stall_inc = (stall_reg == CNT_MAX) ? CNT_MAX : stall_reg + 1'b1;
    assign ret_inc   = (ret_reg == CNT_MAX) ? CNT_MAX : ret_reg + 1'b1;

    assign over_limit  = current_sample > limit_cur;
    assign stall_hit   = CMP_BITS'(stall_inc) > CMP_BITS'(cfg.stall_count_limit);
    assign backoff_run = CMP_BITS'(back_inc) < CMP_BITS'(cfg.backoff_ticks);
    assign up_done     = CMP_BITS'(ret_reg) > CMP_BITS'(cfg.return_ticks);

    // next gate mode
    always_comb
    begin
        mode_next = mode_reg;
        case (op)
            gmsb_pkg::OP_TICK:
            begin
                case (mode_reg)
                    gmsb_pkg::MODE_BACKOFF:
                    begin
                        if (!backoff_run)
                            mode_next = gmsb_pkg::MODE_IDLE;
                    end
                    gmsb_pkg::MODE_DOWN:
                    begin
                        if (over_limit && stall_hit)
                            mode_next = (motor_reg > gmsb_pkg::DRIVE_OFF) ?
                                        gmsb_pkg::MODE_BACKOFF : gmsb_pkg::MODE_IDLE;
                    end
                    gmsb_pkg::MODE_UP:
                    begin
                        if (up_done)
                            mode_next = gmsb_pkg::MODE_IDLE;
                    end
                    default: mode_next = mode_reg;
                endcase
            end
            gmsb_pkg::OP_DOWN:      mode_next = gmsb_pkg::MODE_DOWN;
            gmsb_pkg::OP_UP:        mode_next = gmsb_pkg::MODE_UP;
            gmsb_pkg::OP_STOP_GATE: mode_next = gmsb_pkg::MODE_IDLE;
            gmsb_pkg::OP_STOP_ALL:  mode_next = gmsb_pkg::MODE_IDLE;
            default:                mode_next = mode_reg;
        endcase
    end

    // levels and counters
    always_comb
    begin
        motor_next = motor_reg;
        coll_next  = coll_reg;
        stall_next = stall_reg;
        back_next  = back_reg;
        ret_next   = ret_reg;
        case (op)
            gmsb_pkg::OP_TICK:
            begin
                case (mode_reg)
                    gmsb_pkg::MODE_BACKOFF:
                    begin
                        back_next  = back_inc;
                        motor_next = backoff_run ? gmsb_pkg::DRIVE_BACKOFF
                                                 : gmsb_pkg::DRIVE_OFF;
                    end
                    gmsb_pkg::MODE_DOWN:
                    begin
                        if (over_limit)
                        begin
                            stall_next = stall_inc;
                            if (stall_hit)
                            begin
                                motor_next = gmsb_pkg::DRIVE_OFF;
                                if (motor_reg > gmsb_pkg::DRIVE_OFF)
                                    back_next = '0;
                            end
                        end
                        else
                            stall_next = '0;
                    end
                    gmsb_pkg::MODE_UP:
                    begin
                        if (up_done)
                        begin
                            motor_next = gmsb_pkg::DRIVE_OFF;
                            ret_next   = '0;
                        end
                        else
                            ret_next = ret_inc;
                    end
                    default: motor_next = gmsb_pkg::DRIVE_OFF;
                endcase
            end
            gmsb_pkg::OP_DOWN:
            begin
                motor_next = gmsb_pkg::DRIVE_DOWN;
                ret_next   = '0;
            end
            gmsb_pkg::OP_UP:
            begin
                motor_next = gmsb_pkg::DRIVE_UP;
                ret_next   = '0;
            end
            gmsb_pkg::OP_STOP_GATE:      motor_next = gmsb_pkg::DRIVE_OFF;
            gmsb_pkg::OP_COLLECT:        coll_next  = gmsb_pkg::DRIVE_COLLECT;
            gmsb_pkg::OP_EJECT:          coll_next  = gmsb_pkg::DRIVE_EJECT;
            gmsb_pkg::OP_STOP_COLLECTOR: coll_next  = gmsb_pkg::DRIVE_OFF;
            default:
            begin
                motor_next = gmsb_pkg::DRIVE_OFF;
                coll_next  = gmsb_pkg::DRIVE_OFF;
                stall_next = '0;
                back_next  = '0;
                ret_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= gmsb_pkg::MODE_IDLE;
            motor_reg <= gmsb_pkg::DRIVE_OFF;
            coll_reg  <= gmsb_pkg::DRIVE_OFF;
            stall_reg <= '0;
            back_reg  <= '0;
            ret_reg   <= '0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            motor_reg <= motor_next;
            coll_reg  <= coll_next;
            stall_reg <= stall_next;
            back_reg  <= back_next;
            ret_reg   <= ret_next;
        end
    end

    assign drive_next.motor_drive     = motor_next;
    assign drive_next.collector_drive = coll_next;
    assign drive_next.gate_moving     = (mode_next != gmsb_pkg::MODE_IDLE);

endmodule
`default_nettype wire

### hw/rtl/gate_motor_stall_backoff.sv
// top level: gate motor sequencer with current-stall backoff
// an accepted item passes the input register and then the result register on its way to its result beat
// throughput: one item per cycle while the result is taken, set by the single-pass state update in gmsb_core
// a waiting result stalls the input once the input register also holds a beat
// reset: async active low; drives 0, gate idle, counters 0, config registers to defaults
`default_nettype none
module gate_motor_stall_backoff #(
    parameter int COUNT_BITS   = 16,
    parameter int CURRENT_BITS = 12
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [1:0]                         cfg_index,
    input  wire logic [gmsb_pkg::CFG_DATA_BITS-1:0] cfg_data,
    gmsb_item_if.sink                               item,
    gmsb_result_if.source                           result
);
    gmsb_pkg::cfg_t cfg_reg;

    logic                         s1_valid_reg;
    logic [gmsb_pkg::OP_BITS-1:0] s1_op_reg;
    logic [CURRENT_BITS-1:0]      s1_sample_reg;

    logic             out_valid_reg;
    gmsb_pkg::drive_t out_reg;
    gmsb_pkg::drive_t drive_next;

    logic out_free, fire;

    assign out_free   = !out_valid_reg || result.ready;
    assign fire       = s1_valid_reg && out_free;
    assign item.ready = !s1_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stall_limit_down  <= gmsb_pkg::RST_STALL_LIMIT_DOWN;
            cfg_reg.stall_count_limit <= gmsb_pkg::RST_STALL_COUNT_LIMIT;
            cfg_reg.backoff_ticks     <= gmsb_pkg::RST_BACKOFF_TICKS;
            cfg_reg.return_ticks      <= gmsb_pkg::RST_RETURN_TICKS;
        end
        else if (cfg_we)
        begin
            case (gmsb_pkg::cfg_idx_t'(cfg_index))
                gmsb_pkg::CFG_STALL_LIMIT_DOWN:
                    cfg_reg.stall_limit_down <= cfg_data[gmsb_pkg::LIMIT_BITS-1:0];
                gmsb_pkg::CFG_STALL_COUNT_LIMIT: cfg_reg.stall_count_limit <= cfg_data;
                gmsb_pkg::CFG_BACKOFF_TICKS:     cfg_reg.backoff_ticks     <= cfg_data;
                gmsb_pkg::CFG_RETURN_TICKS:      cfg_reg.return_ticks      <= cfg_data;
                default:                         cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (item.ready)
            s1_valid_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            s1_op_reg     <= item.operation;
            s1_sample_reg <= item.current_sample;
        end
    end

    gmsb_core #(
        .COUNT_BITS   (COUNT_BITS),
        .CURRENT_BITS (CURRENT_BITS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .operation      (s1_op_reg),
        .current_sample (s1_sample_reg),
        .cfg            (cfg_reg),
        .drive_next     (drive_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_reg <= drive_next;
    end

    assign result.valid           = out_valid_reg;
    assign result.motor_drive     = out_reg.motor_drive;
    assign result.collector_drive = out_reg.collector_drive;
    assign result.gate_moving     = out_reg.gate_moving;

    a_idle_motor_off: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.gate_moving) |-> (out_reg.motor_drive == gmsb_pkg::DRIVE_OFF))
        else $error("motor driven while gate idle");

    a_collector_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.collector_drive == gmsb_pkg::DRIVE_OFF ||
                           out_reg.collector_drive == gmsb_pkg::DRIVE_COLLECT ||
                           out_reg.collector_drive == gmsb_pkg::DRIVE_EJECT))
        else $error("collector drive out of set");

    a_stalled_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !result.ready) |=> (s1_valid_reg && out_valid_reg))
        else $error("beat lost under back-pressure");

    a_fire_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("result register not loaded");

endmodule
`default_nettype wire
